>>> rtl/lfla_pkg.sv
// Shared types and constants for the lowest free lease allocator.
// Holds the action codes and the beat that travels down the row of cells.
// No dependencies.
`default_nettype none

package lfla_pkg;

    localparam int STAMP_W     = 32;
    localparam int RELEASE_W   = 33;
    localparam int TOTAL_W     = 48;
    localparam int UNIT_W      = 6;
    localparam int COUNT_W     = 7;
    // Wide enough for any cell position and for the unit count or read index.
    localparam int IDX_CMP_W   = 11;

    localparam logic [COUNT_W-1:0] UNITS_IN_USE_RESET = 7'd64;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX          = {TOTAL_W{1'b1}};

    typedef enum logic [0:0] {
        ACT_ALLOCATE = 1'b0,
        ACT_READ     = 1'b1
    } action_t;

    typedef struct packed {
        logic                 valid;
        action_t              action;
        logic [STAMP_W-1:0]   stamp;
        logic [STAMP_W-1:0]   weight;
        logic [STAMP_W-1:0]   lease;
        logic [UNIT_W-1:0]    unit_to_read;
        logic                 granted;
        logic [UNIT_W-1:0]    granted_unit;
        logic [TOTAL_W-1:0]   total;
    } token_t;

endpackage

`default_nettype wire

>>> rtl/lfla_cell.sv
// One unit of the pool: busy flag, release time and saturating total.
// Processes the beat passing through and hands it to the next cell.
// Depends on lfla_pkg.
`default_nettype none

module lfla_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic [lfla_pkg::COUNT_W-1:0]  units_in_use,
    input  wire lfla_pkg::token_t              tok_in,
    output lfla_pkg::token_t                   tok_out
);
    import lfla_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [RELEASE_W-1:0]  release_reg;
    logic [RELEASE_W-1:0]  release_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    token_t                token_reg;
    token_t                token_next;

    logic                  is_alloc;
    logic                  is_read;
    logic                  expired;
    logic                  enabled;
    logic                  grant;
    logic [TOTAL_W:0]      sum;

    always_comb
    begin
        is_alloc = tok_in.valid && (tok_in.action == ACT_ALLOCATE);
        is_read  = tok_in.valid && (tok_in.action == ACT_READ);
        expired  = busy_reg && (release_reg <= {1'b0, tok_in.stamp});
        enabled  = IDX_CMP_W'(CELL_IDX) < {{(IDX_CMP_W-COUNT_W){1'b0}}, units_in_use};
        grant    = is_alloc && !tok_in.granted && enabled && (!busy_reg || expired);
        sum      = {1'b0, total_reg} + {{(TOTAL_W+1-STAMP_W){1'b0}}, tok_in.weight};

        busy_next    = busy_reg;
        release_next = release_reg;
        total_next   = total_reg;
        token_next   = tok_in;

        if (grant)
        begin
            busy_next    = 1'b1;
            release_next = {1'b0, tok_in.stamp} + {1'b0, tok_in.lease};
            total_next   = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            token_next.granted      = 1'b1;
            token_next.granted_unit = UNIT_W'(CELL_IDX);
        end
        else if (expired && is_alloc)
        begin
            busy_next = 1'b0;
        end

        if (is_read && ({{(IDX_CMP_W-UNIT_W){1'b0}}, tok_in.unit_to_read} ==
                        IDX_CMP_W'(CELL_IDX)))
        begin
            token_next.total = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            total_reg <= '0;
            token_reg <= '0;
        end
        else if (adv)
        begin
            busy_reg  <= busy_next;
            total_reg <= total_next;
            token_reg <= token_next;
        end
    end

    // The release time is only looked at while the unit is busy.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            release_reg <= release_next;
        end
    end

    assign tok_out = token_reg;

endmodule

`default_nettype wire

>>> rtl/lowest_free_lease_allocator.sv
// Lowest-index free unit allocator with lease timers, top level.
// Builds the row of lfla_cell units and the output register.
// Depends on lfla_pkg and lfla_cell.
//
// Usage: an input beat on in_valid/in_ready is either an allocate (action 0)
// or a read of one unit's total (action 1). Each beat yields exactly one
// result beat on out_valid/out_ready, in the order the inputs came in.
// The beat walks down a row of UNITS cells, one cell per clock while the row
// moves. A cell frees its unit when an allocate beat finds it expired, grants
// it if free and below units_in_use and no earlier cell did, and answers a
// read addressed to it. Beats never overtake each other, so every cell sees
// the items in order and a new beat may enter each cycle while the row moves,
// set by the single register stage in each cell. The user writes units_in_use
// through cfg_wr_en/cfg_wr_data only while the block is idle; the block does
// not enforce this. Reset frees every unit, clears all totals, empties the
// row and sets units_in_use to 64. When the receiver holds out_ready low with
// a result waiting, the whole row freezes and in_ready goes low.
`default_nettype none

module lowest_free_lease_allocator #(
    parameter int UNITS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_wr_en,
    input  wire logic [lfla_pkg::COUNT_W-1:0]   cfg_wr_data,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [lfla_pkg::STAMP_W-1:0]   stamp,
    input  wire logic [lfla_pkg::STAMP_W-1:0]   weight,
    input  wire logic [lfla_pkg::STAMP_W-1:0]   lease,
    input  wire logic [lfla_pkg::UNIT_W-1:0]    unit_to_read,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                granted,
    output logic [lfla_pkg::UNIT_W-1:0]         granted_unit,
    output logic [lfla_pkg::TOTAL_W-1:0]        total
);
    import lfla_pkg::*;

    logic [COUNT_W-1:0]  units_in_use_reg;
    logic                adv;
    token_t              tok [0:UNITS];
    logic                out_valid_reg;
    logic                granted_reg;
    logic [UNIT_W-1:0]   granted_unit_reg;
    logic [TOTAL_W-1:0]  total_reg;

    // The row moves whenever the output register is empty or being drained.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_in_use_reg <= UNITS_IN_USE_RESET;
        end
        else if (cfg_wr_en)
        begin
            units_in_use_reg <= cfg_wr_data;
        end
    end

    // The beat entering the first cell; result fields start cleared.
    always_comb
    begin
        tok[0].valid        = in_valid && adv;
        tok[0].action       = action_t'(action);
        tok[0].stamp        = stamp;
        tok[0].weight       = weight;
        tok[0].lease        = lease;
        tok[0].unit_to_read = unit_to_read;
        tok[0].granted      = 1'b0;
        tok[0].granted_unit = '0;
        tok[0].total        = '0;
    end

    for (genvar g = 0; g < UNITS; g++)
    begin : g_cell
        lfla_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .adv          (adv),
            .units_in_use (units_in_use_reg),
            .tok_in       (tok[g]),
            .tok_out      (tok[g+1])
        );
    end

    // Output register: holds a finished result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tok[UNITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            granted_reg      <= tok[UNITS].granted;
            granted_unit_reg <= tok[UNITS].granted_unit;
            total_reg        <= tok[UNITS].total;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign granted_unit = granted_unit_reg;
    assign total        = total_reg;

endmodule

`default_nettype wire
